// File: rtl/lapf_pkg.sv
`timescale 1ns / 1ps

package lapf_pkg;

    localparam int DATA_W     = 32;
    localparam int TAP_W      = 16;
    localparam int PROD_W     = DATA_W + TAP_W;
    localparam int HIST_DEPTH = 8;
    localparam int SLOT_W     = $clog2(HIST_DEPTH);
    localparam int SUM_W      = PROD_W + $clog2(HIST_DEPTH);
    localparam int ORDER_W    = 4;
    localparam int MAX_ORDER  = 8;
    localparam int CTRL_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int ACTION_W   = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FILTER     = 2'd0,
        ACT_HIST_WRITE = 2'd1,
        ACT_HIST_CLEAR = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIR_TAPS     = 3'd0,
        CFG_IIR_TAPS     = 3'd1,
        CFG_FILTER_SHIFT = 3'd2,
        CFG_QUANT_STEP   = 3'd3,
        CFG_TAPS_LO      = 3'd4,
        CFG_TAPS_HI      = 3'd5
    } t_cfg_idx;

    // per-cell control from the top level
    typedef struct packed {
        logic shift;
        logic fb_clear;
        logic fb_load;
        logic use_fir;
        logic use_iir;
        logic tap_en;
    } t_cell_ctrl;

endpackage

// File: rtl/lapf_cell.sv
`timescale 1ns / 1ps

module lapf_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lapf_pkg::t_cell_ctrl                  i_ctrl,
    input  logic        [lapf_pkg::DATA_W-1:0]    i_out_in,
    input  logic        [lapf_pkg::DATA_W-1:0]    i_fb_in,
    input  logic        [lapf_pkg::DATA_W-1:0]    i_fb_wdata,
    input  logic        [lapf_pkg::DATA_W-1:0]    i_fb_src,
    input  logic        [lapf_pkg::TAP_W-1:0]     i_tap,
    output logic        [lapf_pkg::DATA_W-1:0]    o_out_hist,
    output logic        [lapf_pkg::DATA_W-1:0]    o_fb_hist,
    output logic signed [lapf_pkg::PROD_W-1:0]    o_term
);

    logic [lapf_pkg::DATA_W-1:0] r_out_hist, n_out_hist;
    logic [lapf_pkg::DATA_W-1:0] r_fb_hist, n_fb_hist;
    logic [lapf_pkg::DATA_W-1:0] w_operand;

    always_comb begin
        n_out_hist = r_out_hist;
        n_fb_hist  = r_fb_hist;
        if (i_ctrl.shift) begin
            n_out_hist = i_out_in;
            n_fb_hist  = i_fb_in;
        end else if (i_ctrl.fb_clear) begin
            n_fb_hist = '0;
        end else if (i_ctrl.fb_load) begin
            n_fb_hist = i_fb_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_hist <= '0;
            r_fb_hist  <= '0;
        end else begin
            r_out_hist <= n_out_hist;
            r_fb_hist  <= n_fb_hist;
        end
    end

    // fir taps see this cell's output history, iir taps a feedback entry picked upstream
    always_comb begin
        if (!i_ctrl.tap_en) begin
            w_operand = '0;
        end else if (i_ctrl.use_fir) begin
            w_operand = r_out_hist;
        end else if (i_ctrl.use_iir) begin
            w_operand = i_fb_src;
        end else begin
            w_operand = '0;
        end
    end

    assign o_term     = $signed(i_tap) * $signed(w_operand);
    assign o_out_hist = r_out_hist;
    assign o_fb_hist  = r_fb_hist;

endmodule

// File: rtl/lossless_audio_prediction_filter.sv
`timescale 1ns / 1ps

// Prediction filter for one lossless audio channel: turns residuals into samples.
// Input channel (i_in_valid / o_in_ready) carries one request per item: action
// filter yields one result, history write and history clear yield none.
// Output channel (o_out_valid / i_out_ready) carries filtered_sample and
// order_error; a request whose FIR and IIR tap counts together exceed eight returns
// sample 0 with order_error set and leaves the histories alone.
// Throughput: one request per cycle unless the output stalls. The whole prediction
// (eight 16x32 products from the cell row, adder tree, shift, add, mask) is formed
// in the cycle the request is taken, because each sample feeds the very next
// prediction. The result enters the output register in the cycle after acceptance.
// A stalled receiver holds the result; o_in_ready stays high as long as the
// output register is empty or being drained in the same cycle. Reset (synchronous,
// active low) clears all registers but the output sample and error, and both
// histories. Configuration writes via i_cfg_we / i_cfg_addr / i_cfg_wdata take effect
// at once. Issue them only while the block is idle; the block does not enforce this.

module lossless_audio_prediction_filter #(
    parameter int TAP_COUNT = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic        [lapf_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic        [lapf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic        [lapf_pkg::ACTION_W-1:0]  i_action,
    input  logic signed [lapf_pkg::DATA_W-1:0]    i_sample_value,
    input  logic        [lapf_pkg::SLOT_W-1:0]    i_history_slot,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lapf_pkg::DATA_W-1:0]    o_filtered_sample,
    output logic                                  o_order_error
);

    localparam int NCELL = lapf_pkg::HIST_DEPTH;

    logic [lapf_pkg::ORDER_W-1:0]    r_fir_taps, r_iir_taps, r_filter_shift, r_quant_step;
    logic [2*lapf_pkg::CFG_DATA_W-1:0] r_taps;

    logic                            r_out_valid, n_out_valid;
    logic [lapf_pkg::DATA_W-1:0]     r_out_sample, n_out_sample;
    logic                            r_out_err, n_out_err;

    logic                            w_accept;
    logic                            w_order_err;
    logic                            w_shift, w_fb_clear, w_fb_write, w_emit;
    logic [lapf_pkg::DATA_W-1:0]     w_out_hist [NCELL];
    logic [lapf_pkg::DATA_W-1:0]     w_fb_hist  [NCELL];
    logic signed [lapf_pkg::PROD_W-1:0] w_term  [NCELL];
    logic signed [lapf_pkg::SUM_W-1:0]  w_sum;
    logic signed [lapf_pkg::SUM_W-1:0]  w_shifted;
    logic [lapf_pkg::DATA_W-1:0]     w_pred, w_mask, w_sample, w_fb_new;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fir_taps     <= '0;
            r_iir_taps     <= '0;
            r_filter_shift <= '0;
            r_quant_step   <= '0;
            r_taps         <= '0;
        end else if (i_cfg_we) begin
            unique case (lapf_pkg::t_cfg_idx'(i_cfg_addr))
                lapf_pkg::CFG_FIR_TAPS:     r_fir_taps     <= i_cfg_wdata[lapf_pkg::ORDER_W-1:0];
                lapf_pkg::CFG_IIR_TAPS:     r_iir_taps     <= i_cfg_wdata[lapf_pkg::ORDER_W-1:0];
                lapf_pkg::CFG_FILTER_SHIFT: r_filter_shift <= i_cfg_wdata[lapf_pkg::ORDER_W-1:0];
                lapf_pkg::CFG_QUANT_STEP:   r_quant_step   <= i_cfg_wdata[lapf_pkg::ORDER_W-1:0];
                lapf_pkg::CFG_TAPS_LO:      r_taps[lapf_pkg::CFG_DATA_W-1:0] <= i_cfg_wdata;
                lapf_pkg::CFG_TAPS_HI:
                    r_taps[2*lapf_pkg::CFG_DATA_W-1:lapf_pkg::CFG_DATA_W] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_order_err = ({1'b0, r_fir_taps} + {1'b0, r_iir_taps})
                         > (lapf_pkg::ORDER_W + 1)'(lapf_pkg::MAX_ORDER);

    // request decode
    always_comb begin
        w_emit     = 1'b0;
        w_shift    = 1'b0;
        w_fb_clear = 1'b0;
        w_fb_write = 1'b0;
        if (w_accept) begin
            unique case (lapf_pkg::t_action'(i_action))
                lapf_pkg::ACT_FILTER: begin
                    w_emit  = 1'b1;
                    w_shift = !w_order_err;
                end
                lapf_pkg::ACT_HIST_WRITE: w_fb_write = 1'b1;
                lapf_pkg::ACT_HIST_CLEAR: w_fb_clear = 1'b1;
                default: ;
            endcase
        end
    end

    // row of cells, each holding one output and one feedback history entry
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        localparam bit TapEn = (k < TAP_COUNT);
        lapf_pkg::t_cell_ctrl      w_ctrl;
        logic [lapf_pkg::ORDER_W:0] w_iir_idx;
        logic [lapf_pkg::DATA_W-1:0] w_out_in, w_fb_in;

        assign w_iir_idx = (lapf_pkg::ORDER_W + 1)'(k) - {1'b0, r_fir_taps};

        assign w_ctrl.shift    = w_shift;
        assign w_ctrl.fb_clear = w_fb_clear;
        assign w_ctrl.fb_load  = w_fb_write && (i_history_slot == lapf_pkg::SLOT_W'(k));
        assign w_ctrl.use_fir  = (lapf_pkg::ORDER_W + 1)'(k) < {1'b0, r_fir_taps};
        assign w_ctrl.use_iir  = !w_ctrl.use_fir && (w_iir_idx < {1'b0, r_iir_taps});
        assign w_ctrl.tap_en   = TapEn;

        if (k == 0) begin : g_head
            assign w_out_in = w_sample;
            assign w_fb_in  = w_fb_new;
        end else begin : g_body
            assign w_out_in = w_out_hist[k-1];
            assign w_fb_in  = w_fb_hist[k-1];
        end

        lapf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_out_in   (w_out_in),
            .i_fb_in    (w_fb_in),
            .i_fb_wdata (i_sample_value),
            .i_fb_src   (w_fb_hist[w_iir_idx[lapf_pkg::SLOT_W-1:0]]),
            .i_tap      (r_taps[k*lapf_pkg::TAP_W +: lapf_pkg::TAP_W]),
            .o_out_hist (w_out_hist[k]),
            .o_fb_hist  (w_fb_hist[k]),
            .o_term     (w_term[k])
        );
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NCELL; k++) begin
            w_sum = w_sum + {{(lapf_pkg::SUM_W - lapf_pkg::PROD_W){w_term[k][lapf_pkg::PROD_W-1]}},
                             w_term[k]};
        end
    end

    assign w_shifted = w_sum >>> r_filter_shift;
    assign w_pred    = w_shifted[lapf_pkg::DATA_W-1:0];
    assign w_mask    = {lapf_pkg::DATA_W{1'b1}} << r_quant_step;
    assign w_sample  = (w_pred + i_sample_value) & w_mask;
    assign w_fb_new  = w_sample - w_pred;

    // output register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_err    = r_out_err;
        if (w_emit) begin
            n_out_valid  = 1'b1;
            n_out_sample = w_order_err ? '0 : w_sample;
            n_out_err    = w_order_err;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_sample <= n_out_sample;
        r_out_err    <= n_out_err;
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_sample;
    assign o_order_error     = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_order_error) |-> (o_filtered_sample == '0))
        else $error("order error result carries a nonzero sample");

    a_filter_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == lapf_pkg::ACT_FILTER)) |=> o_out_valid)
        else $error("filter request produced no result");

    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !w_shift) |=> ($stable(w_out_hist[0]) && $stable(w_out_hist[NCELL-1])))
        else $error("output history moved without a filter request");

    a_quant_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_order_error) |-> ((o_filtered_sample & ~w_mask) == '0))
        else $error("result has bits set below the quantization step");

endmodule
